// ----- sv/gcsw_pkg.sv -----
// Package: sizes, types, codes and helpers shared by the grid cell set window unit.
package gcsw_pkg;

  localparam int CELL_SLOTS   = 1024;
  localparam int GRID_COLUMNS = 20;
  localparam int ADDR_W       = $clog2(CELL_SLOTS);
  localparam int COL_W        = $clog2(GRID_COLUMNS);
  localparam int ROW_W        = $clog2(CELL_SLOTS / GRID_COLUMNS + 1);
  localparam int CELL_W       = 10;
  localparam int CELL_EXT_W   = 14;
  localparam int CNT_W        = 11;
  localparam int LIM_W        = 16;
  localparam int OUT_COORD_W  = 17;
  localparam int CFG_IDX_W    = 1;

  localparam int WIN_STEP     = 1000;
  localparam int WIN_INIT_MIN = 9999;
  localparam int COORD_MAX    = 65535;
  localparam int COORD_MIN    = -65536;
  localparam int COORD_MAG    = (CELL_SLOTS / GRID_COLUMNS + GRID_COLUMNS + 2) * WIN_STEP * 2
                                + 2 * 65536 + WIN_INIT_MIN;
  localparam int COORD_W      = $clog2(COORD_MAG) + 1;

  localparam int S_TDATA_W    = 16;
  localparam int S_TUSER_W    = 1;
  localparam int OUT_BITS     = 2 + CNT_W + 4 * OUT_COORD_W;
  localparam int M_TDATA_W    = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [LIM_W-1:0] RIGHT_LIMIT_RST = 16'd18000;
  localparam logic [LIM_W-1:0] TOP_LIMIT_RST   = 16'd33000;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RIGHT_LIMIT = 1'b0,
    CFG_TOP_LIMIT   = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    KIND_TOGGLE = 1'b0,
    KIND_WINDOW = 1'b1
  } kind_e;

  typedef struct packed {
    logic accept;
    logic clear_step;
    logic tg_read;
    logic tg_write;
    logic scan_step;
    logic scale;
    logic sq_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic addr_last;
    logic sq_done;
  } status_t;

  function automatic logic [OUT_COORD_W-1:0] sat_coord(coord_t v);
    logic [OUT_COORD_W-1:0] r;
    if (v > coord_t'(COORD_MAX)) begin
      r = OUT_COORD_W'(COORD_MAX);
    end else if (v < coord_t'(COORD_MIN)) begin
      r = OUT_COORD_W'(COORD_MIN);
    end else begin
      r = v[OUT_COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- sv/gcsw_ctrl.sv -----
// Controller: sequences clearing, toggles, bitmap scan, squaring and output beats.
module gcsw_ctrl
  import gcsw_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    s_tvalid_i,
  input  logic    s_kind_i,
  output logic    s_tready_o,
  output logic    m_tvalid_o,
  input  logic    m_tready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [8:0] {
    ST_CLEAR    = 9'b000000001,
    ST_IDLE     = 9'b000000010,
    ST_TG_RD    = 9'b000000100,
    ST_TG_WR    = 9'b000001000,
    ST_WN_SCAN  = 9'b000010000,
    ST_WN_DRAIN = 9'b000100000,
    ST_WN_SCALE = 9'b001000000,
    ST_WN_SQ    = 9'b010000000,
    ST_DONE     = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free   = !out_valid_q || m_tready_i;
  assign s_tready_o = (state_q == ST_IDLE);
  assign m_tvalid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (status_i.addr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.accept = 1'b1;
          state_d = (s_kind_i == KIND_WINDOW) ? ST_WN_SCAN : ST_TG_RD;
        end
      end
      ST_TG_RD: begin
        cmd_o.tg_read = 1'b1;
        state_d = ST_TG_WR;
      end
      ST_TG_WR: begin
        cmd_o.tg_write = 1'b1;
        state_d = ST_DONE;
      end
      ST_WN_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.addr_last) begin
          state_d = ST_WN_DRAIN;
        end
      end
      ST_WN_DRAIN: begin
        state_d = ST_WN_SCALE;
      end
      ST_WN_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d = ST_WN_SQ;
      end
      ST_WN_SQ: begin
        if (status_i.sq_done) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.sq_step = 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- sv/gcsw_dp.sv -----
// Datapath: cell bitmap memory, count, scan counters, bounding box, squaring and output register.
module gcsw_dp
  import gcsw_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  output status_t              status_o,
  input  logic [CELL_W-1:0]    cell_req_i,
  input  logic                 kind_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [LIM_W-1:0]     cfg_data_i,
  output logic [M_TDATA_W-1:0] m_tdata_o
);

  logic                  mem [CELL_SLOTS];
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_waddr, mem_raddr;
  logic                  mem_wdata;
  logic                  rd_q;

  logic [ADDR_W-1:0]     addr_q, addr_d;
  logic [ROW_W-1:0]      row_q, row_d, p_row_q;
  logic [COL_W-1:0]      col_q, col_d, p_col_q;
  logic                  p_valid_q;
  logic [CELL_W-1:0]     cell_q;
  logic                  kind_q;
  logic [CELL_EXT_W-1:0] cell_ext;
  logic                  in_range;
  logic [ADDR_W-1:0]     cell_addr;

  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  present_q, present_d;
  logic                  any_q, any_d;
  logic [LIM_W-1:0]      right_lim_q, top_lim_q;

  coord_t                lft_q, rgt_q, bot_q, top_q;
  coord_t                lft_d, rgt_d, bot_d, top_d;
  coord_t                row_c, col_c, dx, dy, diff_abs;
  logic [M_TDATA_W-1:0]  tdata_q, tdata_d;

  localparam coord_t STEP_C = coord_t'(WIN_STEP);

  assign cell_ext  = CELL_EXT_W'(cell_q);
  assign in_range  = cell_ext < CELL_EXT_W'(CELL_SLOTS);
  assign cell_addr = cell_ext[ADDR_W-1:0];

  assign mem_raddr = cmd_i.tg_read ? cell_addr : addr_q;
  assign mem_we    = cmd_i.clear_step || (cmd_i.tg_write && in_range);
  assign mem_waddr = cmd_i.clear_step ? addr_q : cell_addr;
  assign mem_wdata = cmd_i.clear_step ? 1'b0 : !rd_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[mem_raddr];
  end

  assign status_o.addr_last = (addr_q == ADDR_W'(CELL_SLOTS - 1));

  always_comb begin
    addr_d = addr_q;
    row_d  = row_q;
    col_d  = col_q;
    if (cmd_i.accept) begin
      addr_d = '0;
      row_d  = '0;
      col_d  = '0;
    end else if (cmd_i.clear_step || cmd_i.scan_step) begin
      addr_d = status_o.addr_last ? '0 : addr_q + ADDR_W'(1);
      if (col_q == COL_W'(GRID_COLUMNS - 1)) begin
        col_d = '0;
        row_d = row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_comb begin
    cnt_d     = cnt_q;
    present_d = present_q;
    if (cmd_i.accept) begin
      present_d = 1'b0;
    end else if (cmd_i.tg_write && in_range) begin
      if (rd_q) begin
        present_d = 1'b0;
        if (cnt_q != '0) begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end else begin
        present_d = 1'b1;
        cnt_d = cnt_q + CNT_W'(1);
      end
    end
  end

  assign row_c    = coord_t'({1'b0, p_row_q});
  assign col_c    = coord_t'({1'b0, p_col_q}) - coord_t'(1);
  assign dx       = rgt_q - lft_q;
  assign dy       = top_q - bot_q;
  assign diff_abs = (dx > dy) ? dx - dy : dy - dx;
  assign status_o.sq_done = (dx == dy);

  always_comb begin
    lft_d = lft_q;
    rgt_d = rgt_q;
    bot_d = bot_q;
    top_d = top_q;
    any_d = any_q;
    if (cmd_i.accept) begin
      lft_d = coord_t'(WIN_INIT_MIN);
      bot_d = coord_t'(WIN_INIT_MIN);
      rgt_d = '0;
      top_d = '0;
      any_d = 1'b0;
    end else if (p_valid_q && rd_q) begin
      any_d = 1'b1;
      if (row_c < bot_q) bot_d = row_c;
      if (row_c > top_q) top_d = row_c;
      if (col_c > rgt_q) rgt_d = col_c;
      if (col_c < lft_q) lft_d = col_c;
    end else if (cmd_i.scale) begin
      if (!any_q) begin
        lft_d = '0;
        rgt_d = '0;
        bot_d = '0;
        top_d = '0;
      end else begin
        lft_d = coord_t'(lft_q * STEP_C);
        rgt_d = coord_t'(rgt_q * STEP_C) + STEP_C;
        bot_d = coord_t'(bot_q * STEP_C);
        top_d = coord_t'(top_q * STEP_C) + STEP_C;
      end
    end else if (cmd_i.sq_step) begin
      if (dx < dy) begin
        if (rgt_q < coord_t'({1'b0, right_lim_q})) rgt_d = rgt_q + STEP_C;
        else lft_d = lft_q - STEP_C;
      end else begin
        if (top_q < coord_t'({1'b0, top_lim_q})) top_d = top_q + STEP_C;
        else bot_d = bot_q - STEP_C;
      end
    end
  end

  always_comb begin
    tdata_d = tdata_q;
    if (cmd_i.out_load) begin
      tdata_d = '0;
      if (kind_q == KIND_WINDOW) begin
        tdata_d[OUT_BITS-1:0] = {sat_coord(top_q), sat_coord(bot_q), sat_coord(rgt_q),
                                 sat_coord(lft_q), !any_q, cnt_q, 1'b0};
      end else begin
        tdata_d[OUT_BITS-1:0] = {{(4 * OUT_COORD_W){1'b0}}, 1'b0, cnt_q, present_q};
      end
    end
  end

  assign m_tdata_o = tdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cell_q <= cell_req_i;
      kind_q <= kind_i;
    end
    p_row_q <= row_q;
    p_col_q <= col_q;
    lft_q   <= lft_d;
    rgt_q   <= rgt_d;
    bot_q   <= bot_d;
    top_q   <= top_d;
    tdata_q <= tdata_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q      <= '0;
      row_q       <= '0;
      col_q       <= '0;
      p_valid_q   <= 1'b0;
      cnt_q       <= '0;
      present_q   <= 1'b0;
      any_q       <= 1'b0;
      right_lim_q <= RIGHT_LIMIT_RST;
      top_lim_q   <= TOP_LIMIT_RST;
    end else begin
      addr_q    <= addr_d;
      row_q     <= row_d;
      col_q     <= col_d;
      p_valid_q <= cmd_i.scan_step;
      cnt_q     <= cnt_d;
      present_q <= present_d;
      any_q     <= any_d;
      if (cfg_we_i && cfg_idx_i == CFG_RIGHT_LIMIT) begin
        right_lim_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_idx_i == CFG_TOP_LIMIT) begin
        top_lim_q <= cfg_data_i;
      end
    end
  end

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.tg_write |=> (cnt_q == $past(cnt_q)) || (cnt_q == $past(cnt_q) + CNT_W'(1))
                       || (cnt_q == $past(cnt_q) - CNT_W'(1)))
    else $error("cell count moved by more than one on a toggle");

  a_box_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.scale && any_q) |-> (lft_q <= rgt_q) && (bot_q <= top_q))
    else $error("bounding box inverted after scan");

  a_sq_converge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sq_step |=> diff_abs < $past(diff_abs))
    else $error("squaring step did not narrow the aspect gap");

endmodule

// ----- sv/grid_cell_set_square_window_unit.sv -----
// Top level: grid cell set with squared selection window, controller plus datapath.
//
// Input channel (s_axis): tuser carries kind (0 toggle a cell, 1 request the window),
// tdata carries cell_req. Output channel (m_axis): one result beat per input beat.
// Configuration: cfg_we_i with cfg_idx_i 0 sets right_limit, 1 sets top_limit.
//
// After reset the cell bitmap memory is swept to zero, one entry a cycle; s_tready_o
// stays low during the sweep, configuration writes are taken as ever.
// A toggle goes from acceptance to the result register through one memory read,
// one write-back of the inverted bit and count update, and one output load.
// In a window request the bitmap scan reads one entry a cycle through the single read
// port, then the box is scaled and squared one step of 1000 a cycle until it is square.
// Items are processed one at a time. The result is held in an output register, so the
// next beat is accepted while an earlier result waits; if the receiver stalls, the
// following result waits in its final state until the output register frees.
module grid_cell_set_square_window_unit
  import gcsw_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // [9:0] cell_req, rest zero
  input  logic [S_TUSER_W-1:0] s_axis_tuser,  // [0] kind
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [0] present, [11:1] cell_count, [12] empty_res, [29:13] win_left,
  // [46:30] win_right, [63:47] win_bottom, [80:64] win_top, rest zero
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [LIM_W-1:0]     cfg_data_i
);

  cmd_t    cmd;
  status_t status;

  gcsw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_kind_i   (s_axis_tuser[0]),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  gcsw_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .cell_req_i (s_axis_tdata[CELL_W-1:0]),
    .kind_i     (s_axis_tuser[0]),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .m_tdata_o  (m_axis_tdata)
  );

endmodule

// ----- tb/cell_window_checker.sv -----
// Checker: predicts each result beat of the grid cell set window unit and compares it.
module cell_window_checker
  import gcsw_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // [9:0] cell_req, rest zero
  input  logic [S_TUSER_W-1:0] s_axis_tuser,  // [0] kind
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [0] present, [11:1] cell_count, [12] empty_res, [29:13] win_left,
  // [46:30] win_right, [63:47] win_bottom, [80:64] win_top, rest zero
  input  logic [M_TDATA_W-1:0] m_axis_tdata,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [LIM_W-1:0]     cfg_data_i,
  output int                   open_results_o,
  output int                   mismatches_o
);

  typedef struct packed {
    logic [OUT_COORD_W-1:0] win_top;
    logic [OUT_COORD_W-1:0] win_bottom;
    logic [OUT_COORD_W-1:0] win_right;
    logic [OUT_COORD_W-1:0] win_left;
    logic                   empty_res;
    logic [CNT_W-1:0]       cell_count;
    logic                   present;
  } cell_answer_t;

  localparam int ANSWER_W = $bits(cell_answer_t);

  logic [CELL_SLOTS-1:0] marked_map;
  logic [CNT_W-1:0]      marked_total;
  logic [LIM_W-1:0]      right_lim;
  logic [LIM_W-1:0]      top_lim;
  cell_answer_t          awaited_answers[$];
  int                    mismatch_total = 0;

  function automatic logic [OUT_COORD_W-1:0] clamp_coord(input int v);
    if (v > COORD_MAX) begin
      return OUT_COORD_W'(COORD_MAX);
    end
    if (v < COORD_MIN) begin
      return OUT_COORD_W'(COORD_MIN);
    end
    return OUT_COORD_W'(v);
  endfunction

  function automatic cell_answer_t cell_set_step(input kind_e kind, input logic [CELL_W-1:0] slot);
    cell_answer_t a;
    int lo_x, hi_x, lo_y, hi_y, row, col, i;
    bit any;
    a = '0;
    if (kind == KIND_TOGGLE) begin
      if (int'(slot) < CELL_SLOTS) begin
        if (marked_map[slot]) begin
          marked_map[slot] = 1'b0;
          if (marked_total != '0) begin
            marked_total = marked_total - 1'b1;
          end
        end else begin
          marked_map[slot] = 1'b1;
          marked_total = marked_total + 1'b1;
          a.present = 1'b1;
        end
      end
    end else begin
      lo_x = WIN_INIT_MIN;
      lo_y = WIN_INIT_MIN;
      hi_x = 0;
      hi_y = 0;
      any  = 1'b0;
      for (i = 0; i < CELL_SLOTS; i++) begin
        if (marked_map[i]) begin
          any = 1'b1;
          row = i / GRID_COLUMNS;
          col = i - row * GRID_COLUMNS - 1;
          if (row < lo_y) lo_y = row;
          if (row > hi_y) hi_y = row;
          if (col > hi_x) hi_x = col;
          if (col < lo_x) lo_x = col;
        end
      end
      if (!any) begin
        a.empty_res = 1'b1;
      end else begin
        lo_x = lo_x * WIN_STEP;
        hi_x = hi_x * WIN_STEP + WIN_STEP;
        hi_y = hi_y * WIN_STEP + WIN_STEP;
        lo_y = lo_y * WIN_STEP;
        // widen the narrower axis until the box is square
        while (hi_x - lo_x != hi_y - lo_y) begin
          if (hi_x - lo_x < hi_y - lo_y) begin
            if (hi_x < int'(right_lim)) hi_x += WIN_STEP;
            else lo_x -= WIN_STEP;
          end else begin
            if (hi_y < int'(top_lim)) hi_y += WIN_STEP;
            else lo_y -= WIN_STEP;
          end
        end
        a.win_left   = clamp_coord(lo_x);
        a.win_right  = clamp_coord(hi_x);
        a.win_bottom = clamp_coord(lo_y);
        a.win_top    = clamp_coord(hi_y);
      end
    end
    a.cell_count = marked_total;
    return a;
  endfunction

  task automatic report_field(input string field, input longint want, input longint got);
    $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    mismatch_total++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic [M_TDATA_W+ANSWER_W-1:0] padded;
    cell_answer_t got;
    cell_answer_t want;
    if (!rst_ni) begin
      marked_map   = '0;
      marked_total = '0;
      right_lim    = RIGHT_LIMIT_RST;
      top_lim      = TOP_LIMIT_RST;
      awaited_answers.delete();
      open_results_o <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        padded = {{ANSWER_W{1'b0}}, m_axis_tdata};
        got    = padded[ANSWER_W-1:0];
        if (awaited_answers.size() == 0) begin
          $display("%0t: result beat expected none, got %h", $time, got);
          mismatch_total++;
        end else begin
          want = awaited_answers.pop_front();
          if (got.present !== want.present)
            report_field("present", want.present, got.present);
          if (got.cell_count !== want.cell_count)
            report_field("cell_count", want.cell_count, got.cell_count);
          if (got.empty_res !== want.empty_res)
            report_field("empty_res", want.empty_res, got.empty_res);
          if (got.win_left !== want.win_left)
            report_field("win_left", $signed(want.win_left), $signed(got.win_left));
          if (got.win_right !== want.win_right)
            report_field("win_right", $signed(want.win_right), $signed(got.win_right));
          if (got.win_bottom !== want.win_bottom)
            report_field("win_bottom", $signed(want.win_bottom), $signed(got.win_bottom));
          if (got.win_top !== want.win_top)
            report_field("win_top", $signed(want.win_top), $signed(got.win_top));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        awaited_answers.push_back(cell_set_step(kind_e'(s_axis_tuser[0]),
                                                s_axis_tdata[CELL_W-1:0]));
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_RIGHT_LIMIT: right_lim = cfg_data_i;
          CFG_TOP_LIMIT:   top_lim   = cfg_data_i;
          default: ;
        endcase
      end
      open_results_o <= awaited_answers.size();
    end
    mismatches_o <= mismatch_total;
  end

endmodule

// ----- tb/tb_grid_cell_set_square_window_unit.sv -----
// Testbench top: drives the grid cell set window unit beside its checker and gives the verdict.
module tb_grid_cell_set_square_window_unit;
  import gcsw_pkg::*;

  localparam int N_PHASES        = 7;
  localparam int PHASE_BEATS     = 62;
  localparam int FLOOD_BEATS     = 12;
  localparam int HOLD_OFF_CYCLES = 3000;
  localparam int SETTLE_CYCLES   = 1200;
  localparam int STUCK_LIMIT     = 20000;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic [S_TUSER_W-1:0] s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [LIM_W-1:0]     cfg_data_i;

  int open_results;
  int mismatches;
  bit idle_on  = 1'b1;
  bit hold_req = 1'b0;
  bit holding  = 1'b0;
  int marked_q[$];
  int cluster_centre;

  grid_cell_set_square_window_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  cell_window_checker u_window_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .open_results_o (open_results),
    .mismatches_o   (mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic send_beat(input kind_e kind, input logic [CELL_W-1:0] slot);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= S_TDATA_W'(slot);
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic toggle_cell(input int slot);
    int hits[$];
    hits = marked_q.find_first_index(x) with (x == slot);
    if (hits.size() != 0) marked_q.delete(hits[0]);
    else marked_q.push_back(slot);
    send_beat(KIND_TOGGLE, CELL_W'(slot));
  endtask

  task automatic random_beat();
    int pick, dr, dc, c;
    pick = $urandom_range(0, 99);
    if (pick < 22) begin
      send_beat(KIND_WINDOW, CELL_W'($urandom));
    end else if (pick < 45 && marked_q.size() > 0) begin
      toggle_cell(marked_q[$urandom_range(0, marked_q.size() - 1)]);
    end else if (pick < 82) begin
      dr = int'($urandom_range(0, 6)) - 3;
      dc = int'($urandom_range(0, 6)) - 3;
      c  = cluster_centre + dr * GRID_COLUMNS + dc;
      if (c < 0 || c >= CELL_SLOTS) c = cluster_centre;
      toggle_cell(c);
    end else begin
      toggle_cell($urandom_range(0, CELL_SLOTS - 1));
    end
  endtask

  task automatic wait_until_answered();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (open_results != 0);
  endtask

  task automatic set_limits(input logic [LIM_W-1:0] rl, input logic [LIM_W-1:0] tl);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_RIGHT_LIMIT;
    cfg_data_i <= rl;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_TOP_LIMIT;
    cfg_data_i <= tl;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // result side
  initial begin
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        holding = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        holding  = 1'b0;
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk_i);
      end
    end
  end

  initial begin
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) stuck = 0;
      else stuck++;
    end
    $display("tb_grid_cell_set_square_window_unit failed");
    $finish;
  end

  initial begin
    int phase;
    logic [LIM_W-1:0] rl, tl;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_RIGHT_LIMIT;
    cfg_data_i    <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_beat(KIND_WINDOW, 10'h3FF);
    toggle_cell(0);
    send_beat(KIND_WINDOW, 10'h000);
    toggle_cell(0);
    toggle_cell(20);
    send_beat(KIND_WINDOW, 10'h155);
    toggle_cell(CELL_SLOTS - 1);
    send_beat(KIND_WINDOW, 10'h2AA);
    toggle_cell(19);
    toggle_cell(10'h2AA);
    toggle_cell(10'h155);
    send_beat(KIND_WINDOW, 10'h000);
    toggle_cell(20);
    toggle_cell(CELL_SLOTS - 1);
    send_beat(KIND_WINDOW, 10'h000);
    toggle_cell(19);
    toggle_cell(10'h2AA);
    toggle_cell(10'h155);
    send_beat(KIND_WINDOW, 10'h3FF);

    for (phase = 0; phase < N_PHASES; phase++) begin
      if (phase > 0) begin
        wait_until_answered();
        case (phase)
          1: begin rl = '0;        tl = '0;        end
          2: begin rl = '1;        tl = '1;        end
          3: begin rl = 16'd60000; tl = '0;        end
          4: begin rl = '0;        tl = 16'd60000; end
          default: begin
            rl = LIM_W'($urandom_range(0, 60000));
            tl = LIM_W'($urandom_range(0, 60000));
          end
        endcase
        set_limits(rl, tl);
      end
      idle_on        = (phase != N_PHASES - 1);
      cluster_centre = $urandom_range(0, CELL_SLOTS - 1);
      // drop every marked cell so small boxes come up again
      if (phase % 2 == 1) begin
        while (marked_q.size() > 0) toggle_cell(marked_q[0]);
      end
      if (phase == 2) begin
        hold_req = 1'b1;
        while (!holding) @(posedge clk_i);
        repeat (FLOOD_BEATS) random_beat();
      end
      repeat (PHASE_BEATS) random_beat();
    end

    wait_until_answered();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_grid_cell_set_square_window_unit passed");
    end else begin
      $display("tb_grid_cell_set_square_window_unit failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/gcsw_pkg.sv
sv/gcsw_ctrl.sv
sv/gcsw_dp.sv
sv/grid_cell_set_square_window_unit.sv
tb/cell_window_checker.sv
tb/tb_grid_cell_set_square_window_unit.sv
